// File: src/cpoly_pkg.sv
// ============================================================================
// cpoly_pkg
// Shared widths, fixed-point constants and the queue item type of the
// cosine polynomial block.
// ============================================================================
package cpoly_pkg;

    // external format
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int OUT_W     = FRAC_BITS + 2;

    // internal angle arithmetic carries 32 fraction bits
    localparam int IFRAC      = 32;
    localparam int RSHIFT     = IFRAC - FRAC_BITS;
    localparam int A_W        = IN_W + RSHIFT;
    localparam int Q_W        = 36;
    localparam int Q_HI       = Q_W - IFRAC;
    localparam int P_W        = Q_W + 1;
    localparam int R_W        = P_W - RSHIFT;

    // a mod 2*pi: floor(mag * RCP_TWO_PI / 2^32), RCP_TWO_PI = floor(2^48 / 2*pi in Q.32),
    // is the quotient or one below it for mag <= 2^31; one conditional subtract finishes
    localparam int              MOD_STAGES = 4;
    localparam int              QT_W       = 14;
    localparam int              QE_W       = IN_W + QT_W;
    localparam int              RCP_TP_SH  = 32;
    localparam logic [QT_W-1:0] RCP_TWO_PI = 14'd10430;
    localparam int NEG_DLY     = 8;
    localparam int BACK_STAGES = MOD_STAGES + 12;

    localparam logic [Q_W-1:0] Q_ONE     = 36'h100000000;
    localparam logic [Q_W-1:0] Q_TWO_PI  = 36'h6487ED511;
    localparam logic [Q_W-1:0] Q_PI      = 36'h3243F6A89;
    localparam logic [Q_W-1:0] Q_HALF_PI = 36'h1921FB544;

    // exact reciprocals: x/3 for x < 2^32, x/45 for x < 2^32
    localparam logic [31:0] RCP3     = 32'hAAAAAAAB;
    localparam int          RCP3_SH  = 33;
    localparam logic [32:0] RCP45    = 33'h16C16C16D;
    localparam int          RCP45_SH = 38;
    localparam int          Q24_W    = 64 - RCP3_SH;
    localparam int          Q720_W   = 65 - RCP45_SH;

    localparam logic signed [P_W-1:0]   RND_HALF = P_W'(1) <<< (RSHIFT - 1);
    localparam logic signed [R_W-1:0]   SAT_POS  = R_W'(1) <<< FRAC_BITS;
    localparam logic signed [R_W-1:0]   SAT_NEG  = -SAT_POS;
    localparam logic signed [OUT_W-1:0] OUT_LIM  = OUT_W'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic [A_W-1:0] a;
        logic           reduce;
    } cpoly_item_t;

endpackage

// File: src/cpoly_front.sv
// ============================================================================
// cpoly_front
// Input register: takes the angle magnitude into Q.32 and flags items that
// need reduction modulo 2*pi.
// ============================================================================
module cpoly_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                angle_valid,
    output logic                                angle_ready,
    input  logic signed [cpoly_pkg::IN_W-1:0]   angle,
    input  logic                                q_full,
    output logic                                push,
    output cpoly_pkg::cpoly_item_t              push_item
);
    import cpoly_pkg::*;

    logic           valid_reg;
    logic           valid_next;
    cpoly_item_t    item_reg;
    cpoly_item_t    item_next;
    logic [IN_W-1:0] ang_u;
    logic [IN_W-1:0] mag;

    always_comb
    begin
        ang_u = angle;
        // most negative angle maps to 2^31, still exact unsigned
        mag = ang_u[IN_W-1] ? (~ang_u + 1'b1) : ang_u;
        item_next.a      = {mag, {RSHIFT{1'b0}}};
        item_next.reduce = item_next.a > A_W'(Q_TWO_PI);
    end

    assign angle_ready = !valid_reg || !q_full;
    assign valid_next  = angle_ready ? angle_valid : valid_reg;
    assign push        = valid_reg && !q_full;
    assign push_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (angle_ready && angle_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: src/cpoly_fifo.sv
// ============================================================================
// cpoly_fifo
// Two-entry queue between front and back; head always sits in slot 0.
// ============================================================================
module cpoly_fifo
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  cpoly_pkg::cpoly_item_t  push_item,
    output logic                    full,
    input  logic                    pop,
    output logic                    q_valid,
    output cpoly_pkg::cpoly_item_t  q_item
);
    import cpoly_pkg::*;

    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [1:0]  wr_pos;
    cpoly_item_t slot0_reg;
    cpoly_item_t slot0_next;
    cpoly_item_t slot1_reg;
    cpoly_item_t slot1_next;

    assign full    = cnt_reg == 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_item  = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        wr_pos     = cnt_reg - {1'b0, pop};
        if (pop)
        begin
            slot0_next = slot1_reg;
        end
        if (push)
        begin
            if (wr_pos == 2'd0)
            begin
                slot0_next = push_item;
            end
            else
            begin
                slot1_next = push_item;
            end
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0)
        else $error("pop from empty queue");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// File: src/cpoly_mul.sv
// ============================================================================
// cpoly_mul
// Two-stage Q.32 multiplier: floor(u*v / 2^32) from a 32x32 core product
// and two narrow partial products.
// ============================================================================
module cpoly_mul
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [cpoly_pkg::Q_W-1:0]   u,
    input  logic [cpoly_pkg::Q_W-1:0]   v,
    output logic [cpoly_pkg::Q_W-1:0]   x
);
    import cpoly_pkg::*;

    logic [2*IFRAC-1:0]      ll_reg;
    logic [Q_W+Q_HI-1:0]     hv_reg;
    logic [IFRAC+Q_HI-1:0]   lh_reg;
    logic [Q_W-1:0]          x_reg;
    logic [Q_W+Q_HI-1:0]     sum;

    // uh*v + ul*vh + floor(ul*vl / 2^32) is the exact floor
    assign sum = hv_reg + (Q_W+Q_HI)'(lh_reg) + (Q_W+Q_HI)'(ll_reg[2*IFRAC-1:IFRAC]);
    assign x   = x_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= u[IFRAC-1:0] * v[IFRAC-1:0];
            hv_reg <= u[Q_W-1:IFRAC] * v;
            lh_reg <= u[IFRAC-1:0] * v[Q_W-1:IFRAC];
            x_reg  <= sum[Q_W-1:0];
        end
    end

endmodule

// File: src/cpoly_back.sv
// ============================================================================
// cpoly_back
// Execution pipeline: modulo 2*pi by reciprocal quotient estimate and one
// correction, quadrant fold, Taylor polynomial, rounding and saturation,
// output register.
// ============================================================================
module cpoly_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  cpoly_pkg::cpoly_item_t              q_item,
    output logic                                pop,
    output logic                                cosine_valid,
    input  logic                                cosine_ready,
    output logic signed [cpoly_pkg::OUT_W-1:0]  cosine
);
    import cpoly_pkg::*;

    logic                       adv;
    logic [BACK_STAGES-1:0]     vld_reg;
    logic [BACK_STAGES-1:0]     vld_next;

    logic [IN_W-1:0]            mod_mag;
    logic [QE_W-1:0]            qe_prod;
    logic [QT_W-1:0]            qe_next;
    logic [QT_W-1:0]            qe_reg;
    logic [A_W-1:0]             a0_reg;
    logic [A_W-1:0]             a1_reg;
    logic [A_W-1:0]             qt_reg;
    logic [A_W-1:0]             diff;
    logic [Q_W-1:0]             rem_reg;
    logic [Q_W-1:0]             r_next;
    logic [Q_W-1:0]             r_reg;
    logic [MOD_STAGES-2:0]      red_reg;

    logic [Q_W-1:0]             f1_next;
    logic [Q_W-1:0]             f1_reg;
    logic [Q_W-1:0]             f2_next;
    logic [Q_W-1:0]             f2_reg;
    logic                       neg_next;
    logic                       neg_reg;
    logic [NEG_DLY-1:0]         neg_dly_reg;

    logic [Q_W-1:0]             x2;
    logic [Q_W-1:0]             x4;
    logic [Q_W-1:0]             x6;
    logic [Q_W-1:0]             x2_dly_reg [5];

    logic [63:0]                prod24;
    logic [64:0]                prod720;
    logic [Q24_W-1:0]           q24_reg [3];
    logic [Q720_W-1:0]          q720_reg;

    logic [Q_W-1:0]             pos_next;
    logic [Q_W-1:0]             pos_reg;
    logic [Q_W-1:0]             negt_next;
    logic [Q_W-1:0]             negt_reg;
    logic signed [P_W-1:0]      p_next;
    logic signed [P_W-1:0]      p_reg;
    logic signed [P_W-1:0]      p_rnd;
    logic signed [R_W-1:0]      rs;
    logic signed [R_W-1:0]      sat;
    logic signed [OUT_W-1:0]    cos_reg;

    // whole pipe moves together; the output register holds on a stall
    assign adv          = !cosine_valid || cosine_ready;
    assign pop          = adv && q_valid;
    assign cosine_valid = vld_reg[BACK_STAGES-1];
    assign cosine       = cos_reg;
    assign vld_next     = {vld_reg[BACK_STAGES-2:0], q_valid};

    // quotient estimate, product, difference (below 4*pi), one correction
    always_comb
    begin
        mod_mag = q_item.a[A_W-1:RSHIFT];
        qe_prod = QE_W'(mod_mag) * QE_W'(RCP_TWO_PI);
        qe_next = q_item.reduce ? qe_prod[QE_W-1:RCP_TP_SH] : '0;
        diff    = a1_reg - qt_reg;
        if (red_reg[MOD_STAGES-2] && rem_reg >= Q_TWO_PI)
        begin
            r_next = rem_reg - Q_TWO_PI;
        end
        else
        begin
            r_next = rem_reg;
        end
    end

    // remainder is below 2*pi here, so it fits the Q_W datapath
    always_comb
    begin
        f1_next  = (r_reg > Q_PI) ? (Q_TWO_PI - r_reg) : r_reg;
        neg_next = f1_reg > Q_HALF_PI;
        f2_next  = neg_next ? (Q_PI - f1_reg) : f1_reg;
    end

    cpoly_mul u_mul_x2
    (
        .clk (clk),
        .en  (adv),
        .u   (f2_reg),
        .v   (f2_reg),
        .x   (x2)
    );

    cpoly_mul u_mul_x4
    (
        .clk (clk),
        .en  (adv),
        .u   (x2),
        .v   (x2),
        .x   (x4)
    );

    cpoly_mul u_mul_x6
    (
        .clk (clk),
        .en  (adv),
        .u   (x4),
        .v   (x2_dly_reg[1]),
        .x   (x6)
    );

    // x4/24 = (x4/8)/3, x6/720 = (x6/16)/45
    always_comb
    begin
        prod24    = 64'(x4[Q_W-2:3]) * 64'(RCP3);
        prod720   = 65'(x6[Q_W-1:4]) * 65'(RCP45);
        pos_next  = Q_ONE + Q_W'(q24_reg[2]);
        negt_next = (x2_dly_reg[4] >> 1) + Q_W'(q720_reg);
        if (neg_dly_reg[NEG_DLY-1])
        begin
            p_next = P_W'(negt_reg) - P_W'(pos_reg);
        end
        else
        begin
            p_next = P_W'(pos_reg) - P_W'(negt_reg);
        end
    end

    // round to nearest, ties up, then clamp to +/-1.0
    always_comb
    begin
        p_rnd = p_reg + RND_HALF;
        rs    = R_W'(p_rnd >>> RSHIFT);
        if (rs > SAT_POS)
        begin
            sat = SAT_POS;
        end
        else if (rs < SAT_NEG)
        begin
            sat = SAT_NEG;
        end
        else
        begin
            sat = rs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a0_reg      <= q_item.a;
            qe_reg      <= qe_next;
            a1_reg      <= a0_reg;
            qt_reg      <= A_W'(qe_reg) * A_W'(Q_TWO_PI);
            rem_reg     <= diff[Q_W-1:0];
            r_reg       <= r_next;
            red_reg     <= {red_reg[MOD_STAGES-3:0], q_item.reduce};
            f1_reg      <= f1_next;
            f2_reg      <= f2_next;
            neg_reg     <= neg_next;
            neg_dly_reg <= {neg_dly_reg[NEG_DLY-2:0], neg_reg};
            x2_dly_reg[0] <= x2;
            for (int i = 1; i < 5; i++)
            begin
                x2_dly_reg[i] <= x2_dly_reg[i-1];
            end
            q24_reg[0] <= prod24[63:RCP3_SH];
            q24_reg[1] <= q24_reg[0];
            q24_reg[2] <= q24_reg[1];
            q720_reg   <= prod720[64:RCP45_SH];
            pos_reg    <= pos_next;
            negt_reg   <= negt_next;
            p_reg      <= p_next;
            cos_reg    <= OUT_W'(sat);
        end
    end

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        cosine_valid |-> (cosine <= OUT_LIM) && (cosine >= -OUT_LIM))
        else $error("cosine outside +/-1.0");

    a_vld_shift: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> vld_reg[BACK_STAGES-1] == $past(vld_reg[BACK_STAGES-2]))
        else $error("pipeline valid lost or duplicated");

endmodule

// File: src/cosine_polynomial.sv
// ============================================================================
// cosine_polynomial
// Cosine of a signed fixed-point angle by a sixth-order Taylor polynomial.
// ============================================================================
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------
//  input    | angle_valid / angle_ready    | angle  : s32, Q15.16 radians
//  output   | cosine_valid / cosine_ready  | cosine : s18, Q1.16, +/-1.0 sat
//
//  One item per cycle sustained while the output is not stalled; every stage
//  of the back pipeline holds only compare-subtracts, adds or multiplies of
//  at most 32x33 bits. From acceptance to cosine_valid an item passes the
//  front register, a queue slot, MOD_STAGES reduction stages, 11 fold/poly/round
//  stages and the output register.
//  Reset clears the valid bits and the queue count only; no clearing pass.
//  A stalled output freezes the back pipeline; the two-entry queue and the
//  front register take up to three more items before angle_ready drops.
// ============================================================================
module cosine_polynomial
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                angle_valid,
    output logic                                angle_ready,
    input  logic signed [cpoly_pkg::IN_W-1:0]   angle,
    output logic                                cosine_valid,
    input  logic                                cosine_ready,
    output logic signed [cpoly_pkg::OUT_W-1:0]  cosine
);
    import cpoly_pkg::*;

    logic        q_full;
    logic        push;
    cpoly_item_t push_item;
    logic        pop;
    logic        q_valid;
    cpoly_item_t q_item;

    cpoly_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_valid (angle_valid),
        .angle_ready (angle_ready),
        .angle       (angle),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    cpoly_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    cpoly_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .cosine_valid (cosine_valid),
        .cosine_ready (cosine_ready),
        .cosine       (cosine)
    );

endmodule

// File: bench/cosine_polynomial_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// cosine_polynomial_checker
// Watches both channels of the cosine block. It works out the expected
// cosine of every accepted angle and compares it, in order, with each
// accepted result.
// ============================================================================
module cosine_polynomial_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                angle_valid,
    input  logic                                angle_ready,
    input  logic signed [cpoly_pkg::IN_W-1:0]   angle,
    input  logic                                cosine_valid,
    input  logic                                cosine_ready,
    input  logic signed [cpoly_pkg::OUT_W-1:0]  cosine,
    output int                                  mismatch_count,
    output int                                  pending_count
);

    import cpoly_pkg::*;

    // angle arithmetic with 32 fraction bits, constants rounded to nearest
    localparam int          NORM_SH   = 32 - FRAC_BITS;
    localparam logic [63:0] K_ONE     = 64'h1_0000_0000;
    localparam logic [63:0] K_TWO_PI  = 64'h6_487E_D511;
    localparam logic [63:0] K_PI      = 64'h3_243F_6A89;
    localparam logic [63:0] K_HALF_PI = 64'h1_921F_B544;
    localparam logic [63:0] K_BIAS    = 64'd1 << 36;

    typedef struct {
        logic signed [IN_W-1:0]  angle;
        logic signed [OUT_W-1:0] cosine;
    } cosine_expect_t;

    cosine_expect_t expected_cosines [$];
    cosine_expect_t oldest;

    // floor(u*v / 2^32)
    function automatic logic [63:0] mul_frac32(input logic [63:0] u, input logic [63:0] v);
        logic [127:0] prod;
        prod = u * v;
        return prod[95:32];
    endfunction

    function automatic logic signed [OUT_W-1:0] predict_cosine(
        input logic signed [IN_W-1:0] ang);
        logic [31:0]        bits;
        logic [63:0]        a;
        logic [63:0]        x2;
        logic [63:0]        x4;
        logic [63:0]        x6;
        logic [63:0]        pos;
        logic [63:0]        neg;
        logic [63:0]        u;
        logic signed [63:0] p;
        logic signed [63:0] r;
        logic signed [63:0] lim;
        logic               flip;
        bits = ang;
        // the most negative angle gives 2^31, still exact as unsigned
        if (bits[31])
            bits = ~bits + 32'd1;
        a = {32'd0, bits} << NORM_SH;
        flip = 1'b0;
        // strictly greater: exactly 2*pi is left alone
        if (a > K_TWO_PI)
            a = a % K_TWO_PI;
        if (a > K_PI)
            a = K_TWO_PI - a;
        if (a > K_HALF_PI)
        begin
            a = K_PI - a;
            flip = 1'b1;
        end
        x2 = mul_frac32(a, a);
        x4 = mul_frac32(x2, x2);
        x6 = mul_frac32(x4, x2);
        pos = K_ONE + x4 / 64'd24;
        neg = (x2 >> 1) + x6 / 64'd720;
        p = $signed(pos) - $signed(neg);
        if (flip)
            p = -p;
        // bias up so the shift never sees a negative value; ties go up
        u = 64'(p) + K_BIAS;
        u = (u + (64'd1 << (NORM_SH - 1))) >> NORM_SH;
        r = $signed(u) - $signed(K_BIAS >> NORM_SH);
        lim = 64'sd1 <<< FRAC_BITS;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[OUT_W-1:0];
    endfunction

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cosine_valid && cosine_ready)
            begin
                if (expected_cosines.size() == 0)
                begin
                    $display("%0t: unexpected result cosine=%0d", $time, cosine);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    oldest = expected_cosines.pop_front();
                    if (cosine !== oldest.cosine)
                    begin
                        $display("%0t: angle=%h expected cosine=%0d actual=%0d",
                                 $time, oldest.angle, oldest.cosine, cosine);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (angle_valid && angle_ready)
                expected_cosines.push_back('{angle, predict_cosine(angle)});
            pending_count = expected_cosines.size();
        end
    end

endmodule

// File: bench/cosine_polynomial_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// cosine_polynomial_tb
// Drives angles into the cosine block in random bursts, boundary angles
// first, while the output side stalls on its own pattern, one long hold-off
// among them. The checker predicts and compares; this module gives the
// verdict.
// ============================================================================
module cosine_polynomial_tb;

    import cpoly_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;

    logic                    clk;
    logic                    rst_n;
    logic                    angle_valid;
    logic                    angle_ready;
    logic signed [IN_W-1:0]  angle;
    logic                    cosine_valid;
    logic                    cosine_ready;
    logic signed [OUT_W-1:0] cosine;
    int                      mismatch_count;
    int                      pending_count;
    int                      idle_cycles;

    // zero, +/-1 lsb, extremes, +/-1.0, 0.5, both sides of pi/2, pi, 3pi/2 and 2pi, and 4pi
    localparam logic [31:0] BOUNDARY_ANGLES [20] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
        32'h0001_921F, 32'h0001_9220, 32'hFFFE_6DE1, 32'h0003_243F,
        32'h0003_2440, 32'hFFFC_DBC0, 32'h0004_B65F, 32'h0004_B660,
        32'h0006_487E, 32'h0006_487F, 32'hFFF9_B781, 32'h000C_90FD
    };

    cosine_polynomial uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .angle_valid  (angle_valid),
        .angle_ready  (angle_ready),
        .angle        (angle),
        .cosine_valid (cosine_valid),
        .cosine_ready (cosine_ready),
        .cosine       (cosine)
    );

    cosine_polynomial_checker check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .angle_valid    (angle_valid),
        .angle_ready    (angle_ready),
        .angle          (angle),
        .cosine_valid   (cosine_valid),
        .cosine_ready   (cosine_ready),
        .cosine         (cosine),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_angle(input logic [31:0] value);
        angle_valid <= 1'b1;
        angle       <= value;
        @(posedge clk);
        while (!angle_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // within four turns for the largest share, some full range, some hugging k*pi/2
    function automatic logic [31:0] random_angle();
        int unsigned pick;
        int unsigned k;
        logic [31:0] v;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            v = $urandom;
        else if (pick < 7)
            v = $urandom_range(0, 32'h0019_21FB);
        else
        begin
            k = $urandom_range(0, 40);
            v = k * 32'h0001_921F + $urandom_range(0, 4) - 2;
        end
        if ($urandom_range(0, 1))
            v = ~v + 32'd1;
        return v;
    endfunction

    initial
    begin
        int sent;
        int burst;
        int gap;
        rst_n       = 1'b0;
        angle_valid = 1'b0;
        angle       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (BOUNDARY_ANGLES[i])
            send_angle(BOUNDARY_ANGLES[i]);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send_angle(random_angle());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                angle_valid <= 1'b0;
                angle       <= $urandom;
                repeat (gap) @(negedge clk);
            end
        end
        angle_valid <= 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // output side: ready at first, one long hold-off, then shifting patterns
    initial
    begin
        int mode;
        int span;
        cosine_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        cosine_ready <= 1'b1;
        repeat (150) @(negedge clk);
        cosine_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                case (mode)
                    0: cosine_ready <= 1'b1;
                    1: cosine_ready <= 1'($urandom_range(0, 1));
                    2: cosine_ready <= ($urandom_range(0, 3) == 0);
                    default: cosine_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(negedge clk);
            end
        end
    end

    // cycles with no item moving on either channel
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((angle_valid && angle_ready) || (cosine_valid && cosine_ready))
                    idle_cycles = 0;
                else
                    idle_cycles = idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

endmodule

// File: files.f
src/cpoly_pkg.sv
src/cpoly_front.sv
src/cpoly_fifo.sv
src/cpoly_mul.sv
src/cpoly_back.sv
src/cosine_polynomial.sv
bench/cosine_polynomial_checker.sv
bench/cosine_polynomial_tb.sv
